// ===== rtl/psc_pkg.sv =====
// Shared types and constants of the pressure sensor compensation unit.
// Used by psc_ctrl, psc_datapath and the top level; no dependencies.
`default_nettype none

package psc_pkg;

	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int TEMP_W  = 19;
	localparam int PRES_W  = 32;
	localparam int IDX_W   = 3;

	localparam int DT_W    = 25;
	localparam int MA_W    = 25;
	localparam int MB_W    = 18;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int OFF_W   = 36;
	localparam int SENS_W  = 34;
	localparam int SLO_W   = 17;
	localparam int ACC_W   = PROD_W + SLO_W;
	localparam int DIFF_W  = 39;

	localparam int SHIFT_TEMP     = 23;
	localparam int SHIFT_OFF_REF  = 16;
	localparam int SHIFT_OFF_TC   = 7;
	localparam int SHIFT_SENS_REF = 15;
	localparam int SHIFT_SENS_TC  = 8;
	localparam int SHIFT_PROD     = 21;
	localparam int SHIFT_FINAL    = 15;
	localparam int SHIFT_TREF     = 8;

	localparam logic [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);

	typedef enum logic [IDX_W-1:0] {
		REG_PRESSURE_SENSITIVITY    = 3'd0,
		REG_PRESSURE_OFFSET         = 3'd1,
		REG_TEMP_COEFF_SENSITIVITY  = 3'd2,
		REG_TEMP_COEFF_OFFSET       = 3'd3,
		REG_REFERENCE_TEMPERATURE   = 3'd4,
		REG_TEMPERATURE_COEFFICIENT = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_TEMP = 3'd0,
		MUL_OFF  = 3'd1,
		MUL_SENS = 3'd2,
		MUL_LO   = 3'd3,
		MUL_HI   = 3'd4
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     dt_en;
		mul_sel_t mul_sel;
		logic     temp_en;
		logic     off_en;
		logic     sens_en;
		logic     lo_en;
		logic     hi_en;
		logic     res_en;
	} cmd_t;

	typedef struct packed {
		logic              operation;
		logic [RAW_W-1:0]  raw_value;
	} in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [PRES_W-1:0] pressure;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/psc_ctrl.sv =====
// Sequencer of the compensation unit: steps the shared multiplier through
// one item and owns both handshakes. Depends on psc_pkg.
`default_nettype none

module psc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output psc_pkg::cmd_t      cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DT    = 10'b0000000010,
		S_MTEMP = 10'b0000000100,
		S_MOFF  = 10'b0000001000,
		S_MSENS = 10'b0000010000,
		S_SENS  = 10'b0000100000,
		S_MLO   = 10'b0001000000,
		S_MHI   = 10'b0010000000,
		S_ACC   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = psc_pkg::MUL_TEMP;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_DT;
			end
			S_DT: begin
				cmd.dt_en = 1'b1;
				state_d   = S_MTEMP;
			end
			S_MTEMP: begin
				cmd.mul_sel = psc_pkg::MUL_TEMP;
				state_d     = S_MOFF;
			end
			S_MOFF: begin
				cmd.temp_en = 1'b1;
				cmd.mul_sel = psc_pkg::MUL_OFF;
				state_d     = S_MSENS;
			end
			S_MSENS: begin
				cmd.off_en  = 1'b1;
				cmd.mul_sel = psc_pkg::MUL_SENS;
				state_d     = S_SENS;
			end
			S_SENS: begin
				cmd.sens_en = 1'b1;
				state_d     = S_MLO;
			end
			S_MLO: begin
				cmd.mul_sel = psc_pkg::MUL_LO;
				state_d     = S_MHI;
			end
			S_MHI: begin
				cmd.lo_en   = 1'b1;
				cmd.mul_sel = psc_pkg::MUL_HI;
				state_d     = S_ACC;
			end
			S_ACC: begin
				cmd.hi_en = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				cmd.res_en = slot_free;
				if (slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_en) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/psc_datapath.sv =====
// Datapath of the compensation unit: calibration and raw registers, one
// shared 25x18 signed multiplier, intermediates and the result register.
// Depends on psc_pkg.
`default_nettype none

module psc_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [psc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [psc_pkg::CAL_W-1:0]  cfg_data,
	input  wire psc_pkg::in_t               in_data,
	input  wire psc_pkg::cmd_t              cmd,
	output psc_pkg::out_t                   out_data
);

	localparam int RAW_W  = psc_pkg::RAW_W;
	localparam int CAL_W  = psc_pkg::CAL_W;
	localparam int DT_W   = psc_pkg::DT_W;
	localparam int MA_W   = psc_pkg::MA_W;
	localparam int MB_W   = psc_pkg::MB_W;
	localparam int PROD_W = psc_pkg::PROD_W;
	localparam int OFF_W  = psc_pkg::OFF_W;
	localparam int SENS_W = psc_pkg::SENS_W;
	localparam int SLO_W  = psc_pkg::SLO_W;
	localparam int ACC_W  = psc_pkg::ACC_W;
	localparam int DIFF_W = psc_pkg::DIFF_W;
	localparam int TEMP_W = psc_pkg::TEMP_W;
	localparam int PRES_W = psc_pkg::PRES_W;

	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [RAW_W-1:0] raw_t_q, raw_p_q;

	logic signed [DT_W-1:0]   dt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TEMP_W-1:0]        temp_q;
	logic signed [OFF_W-1:0]  off_q;
	logic signed [SENS_W-1:0] sens_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic signed [PROD_W-1:0] temp_sh, off_sh, sens_sh;
	logic signed [ACC_W-1:0]  acc_hi, acc_sh;
	logic signed [DIFF_W-1:0] diff, diff_sh;
	logic [DT_W-1:0]          dt_d;

	assign dt_d = {1'b0, raw_t_q} - {1'b0, c5_q, psc_pkg::SHIFT_TREF'(0)};

	always_comb begin
		mul_a = dt_q;
		mul_b = $signed({2'b00, c6_q});
		case (cmd.mul_sel)
			psc_pkg::MUL_TEMP: mul_b = $signed({2'b00, c6_q});
			psc_pkg::MUL_OFF:  mul_b = $signed({2'b00, c4_q});
			psc_pkg::MUL_SENS: mul_b = $signed({2'b00, c3_q});
			psc_pkg::MUL_LO: begin
				mul_a = $signed({1'b0, raw_p_q});
				mul_b = $signed({1'b0, sens_q[SLO_W-1:0]});
			end
			psc_pkg::MUL_HI: begin
				mul_a = $signed({1'b0, raw_p_q});
				mul_b = $signed({sens_q[SENS_W-1], sens_q[SENS_W-1:SLO_W]});
			end
			default: mul_b = $signed({2'b00, c6_q});
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign temp_sh = prod_q >>> psc_pkg::SHIFT_TEMP;
	assign off_sh  = prod_q >>> psc_pkg::SHIFT_OFF_TC;
	assign sens_sh = prod_q >>> psc_pkg::SHIFT_SENS_TC;
	assign acc_hi  = $signed({prod_q, SLO_W'(0)});
	assign acc_sh  = acc_q >>> psc_pkg::SHIFT_PROD;
	assign diff    = $signed(acc_sh[DIFF_W-1:0])
	               - $signed({{(DIFF_W-OFF_W){off_q[OFF_W-1]}}, off_q});
	assign diff_sh = diff >>> psc_pkg::SHIFT_FINAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q    <= '0;
			c2_q    <= '0;
			c3_q    <= '0;
			c4_q    <= '0;
			c5_q    <= '0;
			c6_q    <= '0;
			raw_t_q <= '0;
			raw_p_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psc_pkg::REG_PRESSURE_SENSITIVITY:    c1_q <= cfg_data;
					psc_pkg::REG_PRESSURE_OFFSET:         c2_q <= cfg_data;
					psc_pkg::REG_TEMP_COEFF_SENSITIVITY:  c3_q <= cfg_data;
					psc_pkg::REG_TEMP_COEFF_OFFSET:       c4_q <= cfg_data;
					psc_pkg::REG_REFERENCE_TEMPERATURE:   c5_q <= cfg_data;
					psc_pkg::REG_TEMPERATURE_COEFFICIENT: c6_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (in_data.operation) raw_p_q <= in_data.raw_value;
				else raw_t_q <= in_data.raw_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd.dt_en) dt_q <= $signed(dt_d);
		if (cmd.temp_en) temp_q <= psc_pkg::TEMP_BASE + temp_sh[TEMP_W-1:0];
		if (cmd.off_en) begin
			off_q <= $signed({4'b0000, c2_q, psc_pkg::SHIFT_OFF_REF'(0)})
			       + $signed(off_sh[OFF_W-1:0]);
		end
		if (cmd.sens_en) begin
			sens_q <= $signed({3'b000, c1_q, psc_pkg::SHIFT_SENS_REF'(0)})
			        + $signed(sens_sh[SENS_W-1:0]);
		end
		if (cmd.lo_en) acc_q <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		if (cmd.hi_en) acc_q <= acc_q + acc_hi;
		if (cmd.res_en) begin
			out_data.temperature <= $signed(temp_q);
			out_data.pressure    <= $signed(diff_sh[PRES_W-1:0]);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pressure_sensor_compensation_unit.sv =====
// Top level of the pressure sensor compensation unit.
// Instantiates psc_ctrl and psc_datapath; types from psc_pkg.
//
//   channel  dir   handshake               payload
//   in       in    in_valid / in_ready     in_data   (psc_pkg::in_t)
//   out      out   out_valid / out_ready   out_data  (psc_pkg::out_t)
//   cfg      in    cfg_we                  cfg_index, cfg_data
//
// Between acceptances the sequencer runs five products of one item through
// one shared 25x18 multiplier; in_ready is high only while it is idle.
// The result sits in an output register; a new item is taken while it waits.
// If the previous result is still not taken, the last step holds.
// Reset clears calibration words, stored raw values and the handshake state.
`default_nettype none

module pressure_sensor_compensation_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire psc_pkg::in_t               in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output psc_pkg::out_t                   out_data,
	input  wire logic                       cfg_we,
	input  wire logic [psc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [psc_pkg::CAL_W-1:0]  cfg_data
);

	psc_pkg::cmd_t cmd;

	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	psc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== test/psc_compensation_checker.sv =====
// Checker for the pressure sensor compensation unit: tracks calibration writes and
// stored raw readings, predicts each compensated result and compares it on the out channel.
// Depends on psc_pkg for the payload types, register indexes and shift amounts.
module psc_compensation_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire psc_pkg::in_t               in_data,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire psc_pkg::out_t              out_data,
	input  wire logic                       cfg_we,
	input  wire logic [psc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [psc_pkg::CAL_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              expected_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import psc_pkg::*;

	localparam logic   OP_PRESSURE = 1'b1;
	localparam longint TEMP_OFFSET = 2000;

	logic [CAL_W-1:0] c_sens;
	logic [CAL_W-1:0] c_off;
	logic [CAL_W-1:0] c_tc_sens;
	logic [CAL_W-1:0] c_tc_off;
	logic [CAL_W-1:0] c_tref;
	logic [CAL_W-1:0] c_tc_temp;
	logic [RAW_W-1:0] last_temp_raw;
	logic [RAW_W-1:0] last_pres_raw;
	out_t             predicted_results[$];
	out_t             want;

	function automatic out_t compensate(input logic [RAW_W-1:0] raw_t,
			input logic [RAW_W-1:0] raw_p);
		longint dt;
		longint tmp;
		longint off;
		longint sens;
		longint p;
		out_t   res;
		dt   = longint'(raw_t) - (longint'(c_tref) << SHIFT_TREF);
		tmp  = TEMP_OFFSET + ((dt * longint'(c_tc_temp)) >>> SHIFT_TEMP);
		off  = (longint'(c_off) << SHIFT_OFF_REF)
			+ ((longint'(c_tc_off) * dt) >>> SHIFT_OFF_TC);
		sens = (longint'(c_sens) << SHIFT_SENS_REF)
			+ ((longint'(c_tc_sens) * dt) >>> SHIFT_SENS_TC);
		p    = (((longint'(raw_p) * sens) >>> SHIFT_PROD) - off) >>> SHIFT_FINAL;
		res.temperature = tmp[TEMP_W-1:0];
		res.pressure    = p[PRES_W-1:0];
		return res;
	endfunction

	assign expected_count = predicted_results.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_sens        = '0;
			c_off         = '0;
			c_tc_sens     = '0;
			c_tc_off      = '0;
			c_tref        = '0;
			c_tc_temp     = '0;
			last_temp_raw = '0;
			last_pres_raw = '0;
			predicted_results.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$error("result item with no prediction waiting: temperature %0d pressure %0d",
						out_data.temperature, out_data.pressure);
					mismatch_count++;
				end else begin
					want = predicted_results.pop_front();
					if (out_data.temperature !== want.temperature) begin
						$error("temperature: expected %0d, got %0d",
							want.temperature, out_data.temperature);
						mismatch_count++;
					end
					if (out_data.pressure !== want.pressure) begin
						$error("pressure: expected %0d, got %0d",
							want.pressure, out_data.pressure);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_PRESSURE)
					last_pres_raw = in_data.raw_value;
				else
					last_temp_raw = in_data.raw_value;
				predicted_results.push_back(compensate(last_temp_raw, last_pres_raw));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PRESSURE_SENSITIVITY:    c_sens    = cfg_data;
					REG_PRESSURE_OFFSET:         c_off     = cfg_data;
					REG_TEMP_COEFF_SENSITIVITY:  c_tc_sens = cfg_data;
					REG_TEMP_COEFF_OFFSET:       c_tc_off  = cfg_data;
					REG_REFERENCE_TEMPERATURE:   c_tref    = cfg_data;
					REG_TEMPERATURE_COEFFICIENT: c_tc_temp = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== test/pressure_sensor_compensation_unit_test.sv =====
// Top of the pressure sensor compensation unit test: clock, reset, calibration
// writes, raw reading stimulus with random idling, and the verdict.
// Depends on psc_pkg, the block and psc_compensation_checker.
module pressure_sensor_compensation_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import psc_pkg::*;

	localparam logic             OP_TEMPERATURE = 1'b0;
	localparam logic             OP_PRESSURE    = 1'b1;
	localparam logic [IDX_W-1:0] IDX_SPARE_A    = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B    = 3'd7;
	localparam int               CYCLE_LIMIT    = 400000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_data;
	int               mismatch_count;
	int               expected_count;
	int               send_idle;
	int               recv_idle;
	int               cycle_count = 0;

	pressure_sensor_compensation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	psc_compensation_checker compensation_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.expected_count (expected_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_reading(input logic op, input logic [RAW_W-1:0] raw);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		in_data.operation <= op;
		in_data.raw_value <= raw;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_count != 0)
			@(negedge clk);
	endtask

	task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	task automatic load_calibration(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6);
		write_cal(REG_PRESSURE_SENSITIVITY, c1);
		write_cal(REG_PRESSURE_OFFSET, c2);
		write_cal(REG_TEMP_COEFF_SENSITIVITY, c3);
		write_cal(REG_TEMP_COEFF_OFFSET, c4);
		write_cal(REG_REFERENCE_TEMPERATURE, c5);
		write_cal(REG_TEMPERATURE_COEFFICIENT, c6);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return RAW_W'(7000000 + $urandom_range(0, 3000000));
			default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic logic [CAL_W-1:0] pick_cal();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CAL_W'($urandom);
		endcase
	endfunction

	task automatic random_readings(input int count);
		repeat (count)
			send_reading(1'($urandom_range(0, 1)), pick_raw());
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		send_idle = 36;
		recv_idle = 86;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
		send_reading(OP_TEMPERATURE, 24'd8077636);
		send_reading(OP_PRESSURE, 24'd0);
		send_reading(OP_PRESSURE, 24'hFFFFFF);
		send_reading(OP_PRESSURE, 24'd4311550);
		send_reading(OP_TEMPERATURE, 24'd0);
		send_reading(OP_TEMPERATURE, 24'hFFFFFF);
		send_reading(OP_TEMPERATURE, 24'd8077568);
		send_reading(OP_PRESSURE, 24'd1);
		send_reading(OP_TEMPERATURE, 24'd1);
		send_reading(OP_PRESSURE, 24'd6465444);
		send_reading(OP_TEMPERATURE, 24'd12000000);
		send_reading(OP_TEMPERATURE, 24'd6000000);
		drain();

		load_calibration('1, '1, '1, '1, '1, '1);
		send_reading(OP_TEMPERATURE, 24'd0);
		send_reading(OP_PRESSURE, 24'hFFFFFF);
		send_reading(OP_TEMPERATURE, 24'hFFFFFF);
		send_reading(OP_PRESSURE, 24'd0);
		random_readings(150);
		drain();

		send_idle = 86;
		recv_idle = 36;
		load_calibration('0, '0, '0, '0, '0, '0);
		send_reading(OP_PRESSURE, 24'hFFFFFF);
		send_reading(OP_TEMPERATURE, 24'hFFFFFF);
		random_readings(100);
		drain();

		write_cal(IDX_SPARE_A, CAL_W'($urandom));
		write_cal(IDX_SPARE_B, CAL_W'($urandom));
		load_calibration(pick_cal(), pick_cal(), pick_cal(), pick_cal(), pick_cal(),
			pick_cal());
		random_readings(150);
		drain();

		send_idle = 0;
		recv_idle = 0;
		load_calibration(pick_cal(), pick_cal(), pick_cal(), pick_cal(), pick_cal(),
			pick_cal());
		random_readings(150);
		drain();

		load_calibration('1, '0, '1, '0, '1, '0);
		random_readings(100);
		drain();

		load_calibration('0, '1, '0, '1, '0, '1);
		random_readings(100);
		drain();

		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== pressure_sensor_compensation_unit.f =====
rtl/psc_pkg.sv
rtl/psc_ctrl.sv
rtl/psc_datapath.sv
rtl/pressure_sensor_compensation_unit.sv
test/psc_compensation_checker.sv
test/pressure_sensor_compensation_unit_test.sv
